FILE: rtl/core/lwt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lwt_pkg
// Shared types and constants for the last writer tracker: store entry layout,
// command codes, sequencer states and stream field widths.
// ----------------------------------------------------------------------------
package lwt_pkg;

   localparam int unsigned LWT_BUCKET_COUNT = 4096;
   localparam int unsigned LWT_WAY_COUNT    = 4;

   localparam logic [31:0] LWT_HASH_MULT = 32'd2654435761;
   localparam logic [28:0] LWT_LOOKBACK  = 29'd3;
   localparam logic [2:0]  LWT_MAX_WIDTH = 3'd4;

   localparam int unsigned LWT_ADDR_W     = 29;
   localparam int unsigned LWT_SCAN_W     = LWT_ADDR_W + 1;
   localparam int unsigned LWT_REQ_DATA_W = 104;
   localparam int unsigned LWT_REQ_USER_W = 2;
   localparam int unsigned LWT_RSP_DATA_W = 96;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_FIND  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef struct packed {
      logic                  valid;
      logic [2:0]            width;
      logic [LWT_ADDR_W-1:0] address;
      logic [31:0]           value;
      logic [31:0]           pc;
      logic [31:0]           age;
   } entry_type;

   localparam int unsigned LWT_ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REC_RD,
      ST_REC_SCAN,
      ST_REC_WR,
      ST_FIND,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

FILE: rtl/core/lwt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lwt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lwt_ram #(
   parameter int unsigned WIDTH = lwt_pkg::LWT_ENTRY_W,
   parameter int unsigned DEPTH = lwt_pkg::LWT_BUCKET_COUNT
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/last_writer_tracker_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// last_writer_tracker_core
// Set-associative table of recorded memory writes with oldest-age replacement
// and a windowed find that returns the most recent overlapping writer.
// ----------------------------------------------------------------------------
//  channel   dir   handshake              payload
//  req       in    req_tvalid/req_tready  tuser command, tdata write fields
//  rsp       out   rsp_tvalid/rsp_tready  tuser found, tdata found fields
//  csr       in    csr_valid/csr_ready    csr_data tracking enable
//
//  record: the ways are walked one a cycle through the shared age comparator.
//  find: one bucket read per cycle from the way RAMs. clear: every bucket is
//  zeroed. after reset a clearing pass over every bucket runs before
//  req_tready rises; a serial wrap runs the same pass inside a record.
//  one result register: the next beat is taken while a result waits.
// ----------------------------------------------------------------------------
module last_writer_tracker_core #(
   parameter int unsigned BUCKET_COUNT = lwt_pkg::LWT_BUCKET_COUNT,
   parameter int unsigned WAY_COUNT    = lwt_pkg::LWT_WAY_COUNT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: address[31:0], access_width[34:32], write_value[66:35],
   //            writer_pc[98:67], zero[103:99]
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [lwt_pkg::LWT_REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: command[1:0]
   input  wire logic [lwt_pkg::LWT_REQ_USER_W-1:0]  req_tuser,
   // rsp_tdata: found_address[28:0], found_width[31:29], found_value[63:32],
   //            found_pc[95:64]
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [lwt_pkg::LWT_RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: found
   output logic                                     rsp_tuser,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic                                csr_data
);
   import lwt_pkg::*;

   localparam int unsigned IDX_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int unsigned WAY_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
   localparam logic [IDX_W-1:0] MULT_LO   = IDX_W'(LWT_HASH_MULT);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BUCKET_COUNT - 1);
   localparam logic [WAY_W-1:0] LAST_WAY  = WAY_W'(WAY_COUNT - 1);

   // control registers
   state_type            state_ff, state_in;
   state_type            clr_ret_ff, clr_ret_in;
   logic                 en_ff, en_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic [IDX_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [31:0]          serial_ff, serial_in;
   logic                 have_ff, have_in;
   logic                 matched_ff, matched_in;
   logic [2:0]           left_ff, left_in;
   logic                 ev_vld_ff, ev_vld_in;
   logic [WAY_W-1:0]     way_ff, way_in;

   // payload registers
   logic [1:0]            cmd_ff, cmd_in;
   logic [LWT_ADDR_W-1:0] addr_ff, addr_in;
   logic [2:0]            width_ff, width_in;
   logic [31:0]           value_ff, value_in;
   logic [31:0]           pc_ff, pc_in;
   logic [LWT_SCAN_W-1:0] scan_ff, scan_in;
   logic [LWT_SCAN_W-1:0] ev_start_ff, ev_start_in;
   logic [IDX_W-1:0]      bucket_ff, bucket_in;
   logic [WAY_W-1:0]      slot_ff, slot_in;
   entry_type             best_ff, best_in;
   logic [LWT_RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_found_ff, rsp_found_in;

   // memory side
   logic [IDX_W-1:0]       hash_idx;
   logic                   rd_en;
   logic [WAY_COUNT-1:0]   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   entry_type              wr_data;
   logic [LWT_ENTRY_W-1:0] way_raw [WAY_COUNT];
   entry_type              way_ent [WAY_COUNT];

   // find evaluation and shared comparator
   logic [WAY_COUNT-1:0]  hit_vec;
   entry_type             hit_ent;
   entry_type             cur_ent;
   logic [31:0]           cmp_a, cmp_b;
   logic                  cmp_lt;

   // request unpacking
   logic [LWT_ADDR_W-1:0] req_addr;
   logic [2:0]            req_width;
   logic                  req_active;
   logic                  req_low;

   assign req_addr   = req_tdata[LWT_ADDR_W-1:0];
   assign req_width  = req_tdata[34:32];
   assign req_active = en_ff && (req_width != 3'd0) && (req_width <= LWT_MAX_WIDTH);
   assign req_low    = (req_addr < LWT_LOOKBACK);

   // shared hash unit: only the low index bits of the product are needed
   assign hash_idx = IDX_W'(scan_ff[IDX_W-1:0] * MULT_LO);

   for (genvar w = 0; w < WAY_COUNT; w++) begin : g_way
      lwt_ram #(
         .WIDTH (LWT_ENTRY_W),
         .DEPTH (BUCKET_COUNT)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[w]),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (rd_en),
         .rd_addr (hash_idx),
         .rd_data (way_raw[w])
      );
      assign way_ent[w] = entry_type'(way_raw[w]);
      assign hit_vec[w] = way_ent[w].valid &&
                          ({1'b0, way_ent[w].address} == ev_start_ff) &&
                          (({1'b0, ev_start_ff} + (LWT_SCAN_W + 1)'(way_ent[w].width)) >
                           (LWT_SCAN_W + 1)'(addr_ff));
   end

   // at most one way holds a given start address
   always_comb begin
      hit_ent = '0;
      for (int w = 0; w < WAY_COUNT; w++) begin
         if (hit_vec[w]) begin
            hit_ent = entry_type'(hit_ent | way_ent[w]);
         end
      end
   end

   assign cur_ent = way_ent[way_ff];

   always_comb begin
      if (state_ff == ST_REC_SCAN) begin
         cmp_a = cur_ent.age;
         cmp_b = best_ff.age;
      end else begin
         cmp_a = best_ff.age;
         cmp_b = hit_ent.age;
      end
   end
   assign cmp_lt = (cmp_a < cmp_b);

   always_comb begin
      state_in     = state_ff;
      clr_ret_in   = clr_ret_ff;
      en_in        = en_ff;
      rsp_vld_in   = rsp_vld_ff;
      clr_cnt_in   = clr_cnt_ff;
      serial_in    = serial_ff;
      have_in      = have_ff;
      matched_in   = matched_ff;
      left_in      = left_ff;
      ev_vld_in    = ev_vld_ff;
      way_in       = way_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      width_in     = width_ff;
      value_in     = value_ff;
      pc_in        = pc_ff;
      scan_in      = scan_ff;
      ev_start_in  = ev_start_ff;
      bucket_in    = bucket_ff;
      slot_in      = slot_ff;
      best_in      = best_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_found_in = rsp_found_ff;

      rd_en         = 1'b0;
      wr_en         = '0;
      wr_addr       = bucket_ff;
      wr_data.valid   = 1'b1;
      wr_data.width   = width_ff;
      wr_data.address = addr_ff;
      wr_data.value   = value_ff;
      wr_data.pc      = pc_ff;
      wr_data.age     = serial_ff + 32'd1;

      req_tready = (state_ff == ST_IDLE);

      if (csr_valid) begin
         en_in = csr_data;
      end
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en      = '1;
            wr_addr    = clr_cnt_ff;
            wr_data    = '0;
            clr_cnt_in = clr_cnt_ff + IDX_W'(1);
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = clr_ret_ff;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in     = req_tuser;
               addr_in    = req_addr;
               width_in   = req_width;
               value_in   = req_tdata[66:35];
               pc_in      = req_tdata[98:67];
               have_in    = 1'b0;
               matched_in = 1'b0;
               way_in     = '0;
               ev_vld_in  = 1'b0;
               case (req_tuser)
                  CMD_WRITE: begin
                     scan_in  = {1'b0, req_addr};
                     state_in = req_active ? ST_REC_RD : ST_DONE;
                  end
                  CMD_FIND: begin
                     scan_in  = req_low ? '0 : {1'b0, req_addr - LWT_LOOKBACK};
                     left_in  = req_width + (req_low ? 3'(req_addr[1:0])
                                                      : 3'(LWT_LOOKBACK));
                     state_in = req_active ? ST_FIND : ST_DONE;
                  end
                  CMD_CLEAR: begin
                     serial_in  = '0;
                     clr_cnt_in = '0;
                     clr_ret_in = ST_DONE;
                     state_in   = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_REC_RD: begin
            rd_en     = 1'b1;
            bucket_in = hash_idx;
            state_in  = ST_REC_SCAN;
         end
         ST_REC_SCAN: begin
            // in-place hit wins, else last invalid way, else first oldest
            if (!matched_ff) begin
               if (cur_ent.valid && (cur_ent.address == addr_ff)) begin
                  slot_in    = way_ff;
                  matched_in = 1'b1;
               end else if (!have_ff || !cur_ent.valid || cmp_lt) begin
                  slot_in     = way_ff;
                  best_in.age = cur_ent.age;
                  have_in     = 1'b1;
               end
            end
            if (way_ff == LAST_WAY) begin
               state_in = ST_REC_WR;
            end else begin
               way_in = way_ff + WAY_W'(1);
            end
         end
         ST_REC_WR: begin
            if (serial_ff == '1) begin
               // serial wrap: empty the store, then come back and write age 1
               serial_in  = '0;
               clr_cnt_in = '0;
               clr_ret_in = ST_REC_WR;
               state_in   = ST_CLEAR;
            end else begin
               wr_en[slot_ff] = 1'b1;
               serial_in      = serial_ff + 32'd1;
               state_in       = ST_DONE;
            end
         end
         ST_FIND: begin
            if (left_ff != 3'd0) begin
               rd_en       = 1'b1;
               ev_start_in = scan_ff;
               scan_in     = scan_ff + LWT_SCAN_W'(1);
               left_in     = left_ff - 3'd1;
               ev_vld_in   = 1'b1;
            end else begin
               ev_vld_in = 1'b0;
            end
            if (ev_vld_ff && (hit_vec != '0) && (!have_ff || cmp_lt)) begin
               best_in = hit_ent;
               have_in = 1'b1;
            end
            if ((left_ff == 3'd0) && !ev_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in = 1'b1;
               if ((cmd_ff == CMD_FIND) && have_ff) begin
                  rsp_found_in = 1'b1;
                  rsp_data_in  = {best_ff.pc, best_ff.value, best_ff.width,
                                  best_ff.address};
               end else begin
                  rsp_found_in = 1'b0;
                  rsp_data_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ret_ff <= ST_IDLE;
         en_ff      <= 1'b0;
         rsp_vld_ff <= 1'b0;
         clr_cnt_ff <= '0;
         serial_ff  <= '0;
         have_ff    <= 1'b0;
         matched_ff <= 1'b0;
         left_ff    <= '0;
         ev_vld_ff  <= 1'b0;
         way_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ret_ff <= clr_ret_in;
         en_ff      <= en_in;
         rsp_vld_ff <= rsp_vld_in;
         clr_cnt_ff <= clr_cnt_in;
         serial_ff  <= serial_in;
         have_ff    <= have_in;
         matched_ff <= matched_in;
         left_ff    <= left_in;
         ev_vld_ff  <= ev_vld_in;
         way_ff     <= way_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      addr_ff      <= addr_in;
      width_ff     <= width_in;
      value_ff     <= value_in;
      pc_ff        <= pc_in;
      scan_ff      <= scan_in;
      ev_start_ff  <= ev_start_in;
      bucket_ff    <= bucket_in;
      slot_ff      <= slot_in;
      best_ff      <= best_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign csr_ready  = 1'b1;

endmodule
`default_nettype wire

FILE: rtl/core/lwt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lwt_checker
// Port-level checks for the last writer tracker, bound to last_writer_tracker_core.
// ----------------------------------------------------------------------------
module lwt_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic [lwt_pkg::LWT_REQ_DATA_W-1:0]  req_tdata,
   input wire logic [lwt_pkg::LWT_REQ_USER_W-1:0]  req_tuser,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [lwt_pkg::LWT_RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic                                rsp_tuser,
   input wire logic                                csr_valid,
   input wire logic                                csr_ready,
   input wire logic                                csr_data
);
   import lwt_pkg::*;

   // a held result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // a miss carries all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("rsp fields nonzero on a miss");

   // a hit reports a width that could have been recorded
   a_hit_width: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[31:29] != 3'd0) &&
                                  (rsp_tdata[31:29] <= LWT_MAX_WIDTH))
      else $error("rsp hit width out of range");

   // req_tready drops once a command is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken on back-to-back cycles");

   // clearing pass follows reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req ready right after reset");

endmodule

bind last_writer_tracker_core lwt_checker u_lwt_checker (.*);
`default_nettype wire
